// ===== sv/phg_pkg.sv =====
// Shared types, codes and helpers for the Paley Hadamard entry generator.
// Depends on nothing; the order checker and the top level use it.
`default_nettype none

package phg_pkg;

	// Width of the order register and of the row and column indices.
	localparam int ORDER_W = 9;
	localparam int INDEX_W = 8;
	// Bit counter for the serial division over an order-wide dividend.
	localparam int BIT_W = 4;
	// Smallest order that the construction accepts.
	localparam int MIN_ORDER = 4;
	// Order held after reset.
	localparam logic [ORDER_W-1:0] RESET_ORDER = ORDER_W'(4);

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_ORDER = 2'd1,
		ST_RANGE     = 2'd2
	} status_t;

	// Outcome of an order check, reported by the checker for one cycle.
	typedef struct packed {
		logic done;
		logic valid;
	} chk_result_t;

	// Sum of two residues modulo m, where both inputs are already below m.
	function automatic logic [ORDER_W-1:0] add_mod(input logic [ORDER_W-1:0] a,
		input logic [ORDER_W-1:0] b, input logic [ORDER_W-1:0] m);
		logic [ORDER_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, m}) begin
			s = s - {1'b0, m};
		end
		return s[ORDER_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== sv/phg_prime_chk.sv =====
// Order checker: range, multiple of four and primality of n-1 by trial division.
// Each trial divisor is tested by a restoring division, one quotient bit a cycle.
// Depends on phg_pkg.
`default_nettype none

module phg_prime_chk #(
	parameter int MAX_ORDER = 256
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [phg_pkg::ORDER_W-1:0]  order,
	output phg_pkg::chk_result_t              result
);

	typedef enum logic [2:0] {
		K_IDLE = 3'b001,
		K_TEST = 3'b010,
		K_DIV  = 3'b100
	} chk_state_t;

	chk_state_t                       state_q;
	logic [phg_pkg::ORDER_W-1:0]      q_q;
	logic [phg_pkg::ORDER_W-1:0]      div_q;
	logic [phg_pkg::ORDER_W:0]        div_sq_q;
	logic [phg_pkg::ORDER_W-1:0]      rem_q;
	logic [phg_pkg::BIT_W-1:0]        bit_q;
	logic                             done_q;
	logic                             valid_q;

	logic                             order_ok;
	logic [phg_pkg::ORDER_W:0]        rem_shift;
	logic [phg_pkg::ORDER_W-1:0]      rem_next;

	// Range and divisibility screen on the raw order.
	assign order_ok = (32'(order) >= phg_pkg::MIN_ORDER) && (32'(order) <= MAX_ORDER)
		&& (order[1:0] == 2'b00);

	// One step of the restoring division of q by the current divisor.
	always_comb begin
		rem_shift = {rem_q, q_q[bit_q]};
		if (rem_shift >= {1'b0, div_q}) begin
			rem_next = phg_pkg::ORDER_W'(rem_shift - {1'b0, div_q});
		end else begin
			rem_next = rem_shift[phg_pkg::ORDER_W-1:0];
		end
	end

	// Trial division sequencer; the divisor square is kept by increments.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= K_IDLE;
			done_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				K_IDLE: begin
					if (start) begin
						if (!order_ok) begin
							done_q  <= 1'b1;
							valid_q <= 1'b0;
						end else begin
							state_q <= K_TEST;
						end
					end
				end
				K_TEST: begin
					if (div_sq_q > {1'b0, q_q}) begin
						done_q  <= 1'b1;
						valid_q <= 1'b1;
						state_q <= K_IDLE;
					end else begin
						state_q <= K_DIV;
					end
				end
				K_DIV: begin
					if (bit_q == '0) begin
						if (rem_next == '0) begin
							done_q  <= 1'b1;
							valid_q <= 1'b0;
							state_q <= K_IDLE;
						end else begin
							state_q <= K_TEST;
						end
					end
				end
				default: begin
					state_q <= K_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the division.
	always_ff @(posedge clk) begin
		case (state_q)
			K_IDLE: begin
				q_q      <= order - phg_pkg::ORDER_W'(1);
				div_q    <= phg_pkg::ORDER_W'(2);
				div_sq_q <= (phg_pkg::ORDER_W + 1)'(4);
			end
			K_TEST: begin
				rem_q <= '0;
				bit_q <= phg_pkg::BIT_W'(phg_pkg::ORDER_W - 1);
			end
			K_DIV: begin
				rem_q <= rem_next;
				bit_q <= bit_q - phg_pkg::BIT_W'(1);
				if (bit_q == '0) begin
					div_q    <= div_q + phg_pkg::ORDER_W'(1);
					div_sq_q <= div_sq_q + {div_q, 1'b1};
				end
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	assign result = '{done: done_q, valid: valid_q};

	// A division only runs while the divisor square is within q.
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == K_DIV |-> div_sq_q <= {1'b0, q_q})
		else $error("division running past the square-root bound");

	// A report is given only on the way back to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == K_IDLE)
		else $error("check reported while still busy");

	// The divisor never drops below two.
	a_div_min: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == K_DIV |-> div_q >= phg_pkg::ORDER_W'(2))
		else $error("trial divisor below two");

endmodule

`default_nettype wire

// ===== sv/paley_hadamard_entry_generator_core.sv =====
// Paley type I Hadamard entry generator. Each request beat (row, column) gives one
// result beat: +1 on row 0 or column 0, otherwise +1 when (column - row) mod q is a
// quadratic residue, q = order - 1, with a status for a bad order or an index out of
// range. Once the table is built a request reads the single-port residue memory on
// acceptance, then loads the output register when the result channel is free. The
// first request after reset or after an order write first checks the order (trial
// division by each divisor up to the square root of q) and, if it passes, rebuilds
// the table: a clearing pass over q entries, then a pass marking the (q - 1) / 2
// squares. The order register may be written only while no request is in flight.
// Depends on phg_pkg and phg_prime_chk.
`default_nettype none

module paley_hadamard_entry_generator_core #(
	parameter int MAX_ORDER = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Order register write channel.
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [phg_pkg::ORDER_W-1:0]   matrix_order,
	// Request channel.
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [phg_pkg::INDEX_W-1:0]   row_index,
	input  wire logic [phg_pkg::INDEX_W-1:0]   column_index,
	// Result channel.
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               entry_positive,
	output logic [1:0]                         status
);

	localparam int AW    = $clog2(MAX_ORDER);
	localparam int DEPTH = 1 << AW;
	localparam int OW    = phg_pkg::ORDER_W;
	localparam int IW    = phg_pkg::INDEX_W;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_CHECK  = 6'b000010,
		S_CLEAR  = 6'b000100,
		S_MARK   = 6'b001000,
		S_LOOKUP = 6'b010000,
		S_RESP   = 6'b100000
	} state_t;

	state_t                 state_q;
	logic [OW-1:0]          order_q;
	logic                   built_q;
	logic                   order_valid_q;
	logic [IW-1:0]          row_q;
	logic [IW-1:0]          col_q;
	logic [OW-1:0]          cnt_q;
	logic [OW-1:0]          sq_q;
	logic [OW-1:0]          odd_q;
	logic                   residue_mem_q [DEPTH];
	logic                   rd_q;
	logic                   out_valid_q;
	logic                   entry_q;
	phg_pkg::status_t       status_q;

	logic [OW-1:0]          q;
	logic [OW-1:0]          half;
	logic                   chk_start;
	phg_pkg::chk_result_t   chk;
	logic [IW-1:0]          lk_row;
	logic [IW-1:0]          lk_col;
	logic [OW:0]            diff;
	logic [OW-1:0]          lk_offset;
	logic                   rd_en;
	logic                   wr_en;
	logic [OW-1:0]          wr_addr;
	logic                   load_out;

	assign q    = order_q - OW'(1);
	assign half = (q - OW'(1)) >> 1;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign chk_start = (state_q == S_IDLE) && in_valid && !built_q;
	assign load_out  = (state_q == S_RESP) && (!out_valid_q || out_ready);

	phg_prime_chk #(
		.MAX_ORDER(MAX_ORDER)
	) u_chk (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (chk_start),
		.order  (order_q),
		.result (chk)
	);

	// Table offset (column - row) mod q, from the ports on acceptance, in lookup from the held indices.
	always_comb begin
		lk_row = (state_q == S_LOOKUP) ? row_q : row_index;
		lk_col = (state_q == S_LOOKUP) ? col_q : column_index;
		diff   = {2'b00, lk_col} + {1'b0, q} - {2'b00, lk_row};
		if (diff >= {1'b0, q}) begin
			diff = diff - {1'b0, q};
		end
		lk_offset = diff[OW-1:0];
	end

	// Memory port control: the clearing pass writes zero, the marking pass one.
	assign rd_en   = ((state_q == S_IDLE) && in_valid) || (state_q == S_LOOKUP);
	assign wr_en   = (state_q == S_CLEAR) || (state_q == S_MARK);
	assign wr_addr = (state_q == S_MARK) ? sq_q : cnt_q;

	// Residue memory with a registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			residue_mem_q[AW'(wr_addr)] <= (state_q == S_MARK);
		end
		if (rd_en) begin
			rd_q <= residue_mem_q[AW'(lk_offset)];
		end
	end

	// Sequencer: order check, table build and request handling.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			order_q       <= phg_pkg::RESET_ORDER;
			built_q       <= 1'b0;
			order_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= built_q ? S_RESP : S_CHECK;
					end
				end
				S_CHECK: begin
					if (chk.done) begin
						order_valid_q <= chk.valid;
						if (chk.valid) begin
							state_q <= S_CLEAR;
						end else begin
							built_q <= 1'b1;
							state_q <= S_LOOKUP;
						end
					end
				end
				S_CLEAR: begin
					if (cnt_q == q - OW'(1)) begin
						state_q <= S_MARK;
					end
				end
				S_MARK: begin
					if (cnt_q == half) begin
						built_q <= 1'b1;
						state_q <= S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// An order write forces a fresh check on the next request.
			if (cfg_valid) begin
				order_q <= matrix_order;
				built_q <= 1'b0;
			end
		end
	end

	// Build counters: squares mod q follow by adding successive odd numbers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					row_q <= row_index;
					col_q <= column_index;
				end
			end
			S_CHECK: begin
				cnt_q <= '0;
			end
			S_CLEAR: begin
				if (cnt_q == q - OW'(1)) begin
					cnt_q <= OW'(1);
					sq_q  <= OW'(1);
					odd_q <= phg_pkg::add_mod(OW'(1), OW'(2), q);
				end else begin
					cnt_q <= cnt_q + OW'(1);
				end
			end
			S_MARK: begin
				cnt_q <= cnt_q + OW'(1);
				sq_q  <= phg_pkg::add_mod(sq_q, odd_q, q);
				odd_q <= phg_pkg::add_mod(odd_q, OW'(2), q);
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (!order_valid_q) begin
				status_q <= phg_pkg::ST_BAD_ORDER;
				entry_q  <= 1'b0;
			end else if (({1'b0, row_q} >= order_q) || ({1'b0, col_q} >= order_q)) begin
				status_q <= phg_pkg::ST_RANGE;
				entry_q  <= 1'b0;
			end else begin
				status_q <= phg_pkg::ST_OK;
				entry_q  <= (row_q == '0) || (col_q == '0) || rd_q;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign entry_positive = entry_q;
	assign status         = status_q;

	// An error result never reports a positive entry.
	a_err_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != phg_pkg::ST_OK) |-> !entry_positive)
		else $error("positive entry reported with an error status");

	// One request at a time: acceptance closes the request channel.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while one is in flight");

	// Squares are marked only for an order that passed the check.
	a_mark_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MARK |-> order_valid_q)
		else $error("table built for an invalid order");

	// The checker reports only while the sequencer waits for it.
	a_chk_done: assert property (@(posedge clk) disable iff (!arst_n)
		chk.done |-> state_q == S_CHECK)
		else $error("order check finished outside the check phase");

endmodule

`default_nettype wire
